@@ hw/rtl/kps_pkg.sv @@
// kps_pkg: shared types and constants for the keyed priority store.
// Holds field widths, status and kind codes, and the controller state type.
// No dependencies.
`default_nettype none

package kps_pkg;

    localparam int SLOTS_DEFAULT = 128;

    localparam int KEY_W    = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_UNNAMED  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_APPENDED = 2'd3
    } status_t;

    typedef enum logic {
        KIND_SET = 1'b0,
        KIND_GET = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/kps_ram.sv @@
// kps_ram: generic single-write, single-read RAM with a registered read.
// Used by the keyed priority store for its key/priority table. No dependencies.
`default_nettype none

module kps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/keyed_priority_store.sv @@
// keyed_priority_store: append-only table mapping a thread id to a priority.
// Depends on kps_pkg and kps_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   req     | in        | req_valid/req_stall  | kind, thread_id, priority_req
//   rsp     | out       | rsp_valid/rsp_stall  | priority_value, found, status,
//           |           |                      | unnamed_total, full_total
//
// Search: an item is compared against the filled entries in order from entry
//   zero until a match or the last filled entry; an unnamed id or an empty
//   table skips the search. The linear search reads one table entry per cycle
//   from the single read port, and no new item is taken until the current one is done.
// Reset clears the controller, the fill count and both counters; table
//   contents are not cleared, entries at or above the fill count are never read.
// A stalled result waits in the output register; the next item is still
//   accepted and searched, and only its own result waits for the register.
`default_nettype none

module keyed_priority_store
    import kps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic                     kind,
    input  wire logic [KEY_W-1:0]         thread_id,
    input  wire logic signed [PRIO_W-1:0] priority_req,
    // response channel
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output logic signed [PRIO_W-1:0]      priority_value,
    output logic                          found,
    output logic [STATUS_W-1:0]           status,
    output logic [TOTAL_W-1:0]            unnamed_total,
    output logic [TOTAL_W-1:0]            full_total
);

    localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int WORDW = KEY_W + PRIO_W;

    // Controller state
    state_t                   state_reg, state_next;
    logic [IDXW-1:0]          idx_reg, idx_next;
    logic [CNTW-1:0]          count_reg, count_next;
    logic [TOTAL_W-1:0]       unnamed_reg, unnamed_next;
    logic [TOTAL_W-1:0]       full_reg, full_next;

    // Item being worked on (payload, no reset)
    logic                     kind_reg, kind_next;
    logic [KEY_W-1:0]         id_reg, id_next;
    logic [PRIO_W-1:0]        prio_reg, prio_next;

    // Finished result waiting for the output register
    logic [PRIO_W-1:0]        res_value_reg, res_value_next;
    logic                     res_found_reg, res_found_next;
    status_t                  res_status_reg, res_status_next;

    // Output register
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [PRIO_W-1:0]        out_value_reg, out_value_next;
    logic                     out_found_reg, out_found_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [TOTAL_W-1:0]       out_unnamed_reg, out_unnamed_next;
    logic [TOTAL_W-1:0]       out_full_reg, out_full_next;

    // Table port
    logic                     wr_en;
    logic [IDXW-1:0]          wr_addr;
    logic [WORDW-1:0]         wr_data;
    logic                     rd_en;
    logic [IDXW-1:0]          rd_addr;
    logic [WORDW-1:0]         rd_data;

    logic                     accept;
    logic                     hit;
    logic                     last_entry;
    logic                     table_full;

    // Each word holds the key in the upper bits and the priority below it.
    kps_ram #(
        .WIDTH (WORDW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // Compare the entry read last cycle against the key under search.
    assign hit        = (rd_data[WORDW-1:PRIO_W] == id_reg);
    assign last_entry = ((CNTW'(idx_reg) + CNTW'(1)) == count_reg);
    assign table_full = (count_reg == CNTW'(SLOTS));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        unnamed_next     = unnamed_reg;
        full_next        = full_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        prio_next        = prio_reg;
        res_value_next   = res_value_reg;
        res_found_next   = res_found_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg;
        out_value_next   = out_value_reg;
        out_found_next   = out_found_reg;
        out_status_next  = out_status_reg;
        out_unnamed_next = out_unnamed_reg;
        out_full_next    = out_full_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;

        // Drop the output item once it is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = kind;
                    id_next         = thread_id;
                    prio_next       = priority_req;
                    idx_next        = '0;
                    res_value_next  = '0;
                    res_found_next  = 1'b0;
                    res_status_next = STAT_OK;
                    if (thread_id == '0)
                    begin
                        // Unnamed handle: count it, leave the table alone.
                        unnamed_next    = unnamed_reg + TOTAL_W'(1);
                        res_status_next = STAT_UNNAMED;
                        state_next      = ST_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty table: nothing to search.
                        if (kind == KIND_SET)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = '0;
                            wr_data         = {thread_id, priority_req};
                            count_next      = CNTW'(1);
                            res_status_next = STAT_APPENDED;
                        end
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        // Start the scan at entry zero.
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (hit)
                begin
                    if (kind_reg == KIND_SET)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = {id_reg, prio_reg};
                    end
                    else
                    begin
                        res_value_next = rd_data[PRIO_W-1:0];
                        res_found_next = 1'b1;
                    end
                    res_status_next = STAT_OK;
                    state_next      = ST_RESULT;
                end
                else if (last_entry)
                begin
                    if (kind_reg == KIND_SET)
                    begin
                        if (table_full)
                        begin
                            full_next       = full_reg + TOTAL_W'(1);
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDXW-1:0];
                            wr_data         = {id_reg, prio_reg};
                            count_next      = count_reg + CNTW'(1);
                            res_status_next = STAT_APPENDED;
                        end
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    // Advance to the next filled entry.
                    idx_next = idx_reg + IDXW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDXW'(1);
                end
            end

            ST_RESULT:
            begin
                // Hold until the output register is free or being emptied.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    out_value_next   = res_value_reg;
                    out_found_next   = res_found_reg;
                    out_status_next  = res_status_reg;
                    out_unnamed_next = unnamed_reg;
                    out_full_next    = full_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            unnamed_reg   <= '0;
            full_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            unnamed_reg   <= unnamed_next;
            full_reg      <= full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        prio_reg        <= prio_next;
        res_value_reg   <= res_value_next;
        res_found_reg   <= res_found_next;
        res_status_reg  <= res_status_next;
        out_value_reg   <= out_value_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
        out_unnamed_reg <= out_unnamed_next;
        out_full_reg    <= out_full_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign priority_value = out_value_reg;
    assign found          = out_found_reg;
    assign status         = out_status_reg;
    assign unnamed_total  = out_unnamed_reg;
    assign full_total     = out_full_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kps_chk.sv @@
// kps_chk: port-level checks for the keyed priority store, bound to the top.
// Depends on kps_pkg for the status codes.
`default_nettype none

module kps_chk
    import kps_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     req_valid,
    input wire logic                     req_stall,
    input wire logic                     rsp_valid,
    input wire logic                     rsp_stall,
    input wire logic signed [PRIO_W-1:0] priority_value,
    input wire logic                     found,
    input wire logic [STATUS_W-1:0]      status,
    input wire logic [TOTAL_W-1:0]       unnamed_total,
    input wire logic [TOTAL_W-1:0]       full_total
);

    // One item at a time: an accepted item always blocks the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken back to back");

    // A found flag only comes with a plain ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && found) |-> (status == STAT_OK))
        else $error("found with non-ok status");

    // Without a hit the priority reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !found) |-> (priority_value == '0))
        else $error("nonzero priority without a hit");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=>
            (rsp_valid && $stable(status) && $stable(full_total)
             && $stable(unnamed_total)))
        else $error("stalled result changed");

endmodule

bind keyed_priority_store kps_chk u_kps_chk (.*);

`default_nettype wire
